// ===== hdl/clt_pkg.sv =====
package clt_pkg;

    localparam logic [7:0] QUOTE_CH    = 8'h22;
    localparam logic [7:0] BSLASH_CH   = 8'h5C;
    localparam logic [7:0] DELIM_RESET = 8'd32;

    // token index saturates at 127, slash run at 256
    localparam logic [6:0] TOK_CAP   = 7'd127;
    localparam logic [8:0] SLASH_CAP = 9'd256;

    localparam logic REC_CHAR    = 1'b0;
    localparam logic REC_SUMMARY = 1'b1;

    localparam int MAX_RECS = 3;

    typedef struct packed {
        logic       quote_mode;
        logic [8:0] pending_slashes;
        logic [6:0] current_token;
        logic       line_start;
        logic       in_delim_run;
        logic       overflow_seen;
    } line_state_t;

    localparam line_state_t LINE_RESET = '{
        quote_mode:      1'b0,
        pending_slashes: 9'd0,
        current_token:   7'd0,
        line_start:      1'b1,
        in_delim_run:    1'b0,
        overflow_seen:   1'b0
    };

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic [8:0] len;
    } rec_t;

    // records caused by one item; tok/ovf are shared by all of them
    typedef struct packed {
        logic [1:0] count;
        rec_t [MAX_RECS-1:0] recs;
        logic [6:0] tok;
        logic       ovf;
    } rec_set_t;

endpackage

// ===== hdl/command_line_tokenizer_unit.sv =====
// Byte-serial command line splitter.
// Input channel s_: one byte of the line per item, s_tlast marks the final byte.
// Output channel m_: records; m_tuser 0 is a character run (out_byte repeated
// run_length times into token tok_index), 1 is the end-of-line summary giving the
// final token index. m_tlast flags the last record caused by one input byte.
// cfg_we/cfg_wdata set the delimiter byte (reset 32, space); the user is to
// write it only between lines, the block does not enforce this. Throughput: one
// byte per cycle while m_tready is high and each byte yields at most one record;
// a byte with more (at most 3: backslash runs ended by a quote or another byte,
// plus the summary) holds the record buffer until its last record is taken. Bytes
// that yield no record (delimiters, quotes, backslashes) do not wait for it.
// The line state updates in one pass when a byte leaves the input register.
// Reset (aresetn low, synchronous) empties both registers and returns the line
// state and delimiter to their reset values. When m_tready is low the record
// buffer holds, the input register fills and s_tready drops; nothing is lost.
module command_line_tokenizer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // in_byte[7:0]
    input  logic        s_tlast,    // in_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // out_byte[7:0], run_length[16:8],
                                    // tok_index[23:17], overflow[24], zero fill
    output logic        m_tuser,    // rec_kind
    output logic        m_tlast     // out_last
);

    logic                 a_valid_reg;
    logic [7:0]           a_byte_reg;
    logic                 a_end_reg;
    logic [7:0]           delim_reg;
    clt_pkg::line_state_t st_reg, st_next;
    clt_pkg::rec_set_t    rset;
    logic                 buf_free;
    logic                 a_adv;
    logic                 load;

    clt_step u_step (
        .st      (st_reg),
        .delim   (delim_reg),
        .in_byte (a_byte_reg),
        .in_end  (a_end_reg),
        .st_next (st_next),
        .rset    (rset)
    );

    clt_rec_buf u_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .load_set (rset),
        .free     (buf_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    assign a_adv    = a_valid_reg && ((rset.count == 2'd0) || buf_free);
    assign load     = a_adv && (rset.count != 2'd0);
    assign s_tready = !a_valid_reg || a_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            st_reg      <= clt_pkg::LINE_RESET;
            delim_reg   <= clt_pkg::DELIM_RESET;
        end else begin
            if (s_tready) begin
                a_valid_reg <= s_tvalid;
            end
            if (a_adv) begin
                st_reg <= st_next;
            end
            if (cfg_we) begin
                delim_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            a_byte_reg <= s_tdata;
            a_end_reg  <= s_tlast;
        end
    end

    // a summary always closes the records of its byte
    a_summary_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == clt_pkg::REC_SUMMARY)) |-> m_tlast)
        else $error("summary record without tlast");

    a_summary_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == clt_pkg::REC_SUMMARY)) |-> (m_tdata[16:0] == 17'd0))
        else $error("summary record carries character data");

    a_char_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == clt_pkg::REC_CHAR)) |-> (m_tdata[16:8] != 9'd0))
        else $error("zero-length character run");

    // line start only after reset or a summary, so the rest of the state is clear
    a_line_start_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.line_start |-> ((st_reg.pending_slashes == 9'd0) && !st_reg.quote_mode
                               && (st_reg.current_token == 7'd0) && !st_reg.overflow_seen))
        else $error("line start with stale line state");

endmodule

// ===== hdl/clt_step.sv =====
module clt_step (
    input  clt_pkg::line_state_t st,
    input  logic [7:0]           delim,
    input  logic [7:0]           in_byte,
    input  logic                 in_end,
    output clt_pkg::line_state_t st_next,
    output clt_pkg::rec_set_t    rset
);

    always_comb begin
        clt_pkg::line_state_t ns;
        clt_pkg::rec_set_t    rs;
        logic [1:0]           n;
        logic [8:0]           half;

        ns   = st;
        rs   = '0;
        n    = 2'd0;
        half = st.pending_slashes >> 1;

        if (st.pending_slashes != 9'd0) begin
            if (in_byte == clt_pkg::BSLASH_CH) begin
                if (st.pending_slashes < clt_pkg::SLASH_CAP) begin
                    ns.pending_slashes = st.pending_slashes + 9'd1;
                end
            end else if (in_byte == clt_pkg::QUOTE_CH) begin
                if (half != 9'd0) begin
                    rs.recs[n] = '{kind: clt_pkg::REC_CHAR, data: clt_pkg::BSLASH_CH,
                                   len: half};
                    n = n + 2'd1;
                end
                if (st.pending_slashes[0]) begin
                    rs.recs[n] = '{kind: clt_pkg::REC_CHAR, data: clt_pkg::QUOTE_CH,
                                   len: 9'd1};
                    n = n + 2'd1;
                end else begin
                    ns.quote_mode = ~st.quote_mode;
                end
                ns.pending_slashes = 9'd0;
            end else begin
                rs.recs[n] = '{kind: clt_pkg::REC_CHAR, data: clt_pkg::BSLASH_CH,
                               len: st.pending_slashes};
                n = n + 2'd1;
                rs.recs[n] = '{kind: clt_pkg::REC_CHAR, data: in_byte, len: 9'd1};
                n = n + 2'd1;
                ns.pending_slashes = 9'd0;
            end
            ns.in_delim_run = 1'b0;
        end else if (in_byte == delim) begin
            if (st.quote_mode) begin
                rs.recs[n] = '{kind: clt_pkg::REC_CHAR, data: in_byte, len: 9'd1};
                n = n + 2'd1;
                ns.in_delim_run = 1'b0;
            end else if (!st.in_delim_run) begin
                ns.in_delim_run = 1'b1;
                if (!st.line_start) begin
                    if (st.current_token < clt_pkg::TOK_CAP) begin
                        ns.current_token = st.current_token + 7'd1;
                    end else begin
                        ns.overflow_seen = 1'b1;
                    end
                end
            end
        end else if (in_byte == clt_pkg::QUOTE_CH) begin
            ns.quote_mode   = ~st.quote_mode;
            ns.in_delim_run = 1'b0;
        end else if (in_byte == clt_pkg::BSLASH_CH) begin
            ns.pending_slashes = 9'd1;
            ns.in_delim_run    = 1'b0;
        end else begin
            rs.recs[n] = '{kind: clt_pkg::REC_CHAR, data: in_byte, len: 9'd1};
            n = n + 2'd1;
            ns.in_delim_run = 1'b0;
        end
        ns.line_start = 1'b0;

        // character records never coincide with a token advance, so the updated index fits all
        rs.tok = ns.current_token;
        rs.ovf = ns.overflow_seen;

        if (in_end) begin
            if (ns.pending_slashes != 9'd0) begin
                rs.recs[n] = '{kind: clt_pkg::REC_CHAR, data: clt_pkg::BSLASH_CH,
                               len: ns.pending_slashes};
                n = n + 2'd1;
            end
            rs.recs[n] = '{kind: clt_pkg::REC_SUMMARY, data: 8'd0, len: 9'd0};
            n = n + 2'd1;
            ns = clt_pkg::LINE_RESET;
        end

        rs.count = n;
        st_next  = ns;
        rset     = rs;
    end

endmodule

// ===== hdl/clt_rec_buf.sv =====
module clt_rec_buf (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  clt_pkg::rec_set_t  load_set,
    output logic               free,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata,   // out_byte[7:0], run_length[16:8],
                                          // tok_index[23:17], overflow[24], zero fill
    output logic               m_tuser,   // rec_kind
    output logic               m_tlast    // out_last
);

    logic [1:0]                            cnt_reg, cnt_next;
    logic [1:0]                            idx_reg, idx_next;
    clt_pkg::rec_t [clt_pkg::MAX_RECS-1:0] recs_reg;
    logic [6:0]                            tok_reg;
    logic                                  ovf_reg;
    clt_pkg::rec_t                         cur;
    logic                                  last;
    logic                                  take;

    assign cur      = recs_reg[idx_reg];
    assign last     = (idx_reg == (cnt_reg - 2'd1));
    assign m_tvalid = (cnt_reg != 2'd0);
    assign take     = m_tvalid && m_tready;
    assign free     = !m_tvalid || (m_tready && last);

    assign m_tdata = {7'd0, ovf_reg, tok_reg, cur.len, cur.data};
    assign m_tuser = cur.kind;
    assign m_tlast = last;

    always_comb begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (take) begin
            if (last) begin
                cnt_next = 2'd0;
                idx_next = 2'd0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
        if (load) begin
            cnt_next = load_set.count;
            idx_next = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            recs_reg <= load_set.recs;
            tok_reg  <= load_set.tok;
            ovf_reg  <= load_set.ovf;
        end
    end

endmodule

// ===== tb/sv/tb_command_line_tokenizer_unit.sv =====
module tb_command_line_tokenizer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
        logic [8:0] len;
        logic [6:0] tok;
        logic       ovf;
        logic       last;
    } record_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    command_line_tokenizer_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // tokenizer state mirrored by the testbench
    logic [7:0] delim_reg;
    logic       quote_on;
    logic [8:0] bslash_run;
    logic [6:0] tok_idx;
    logic       at_line_start;
    logic       delim_run;
    logic       tok_ovf;

    record_t expected_records[$];

    int  mismatches      = 0;
    int  records_checked = 0;
    int  bytes_sent      = 0;
    int  lines_sent      = 0;
    int  delim_settings  = 0;
    int  stall_left      = 0;
    bit  gaps_on         = 1'b1;
    bit  stalls_on       = 1'b1;

    task automatic clear_line_state();
        quote_on      = 1'b0;
        bslash_run    = '0;
        tok_idx       = '0;
        at_line_start = 1'b1;
        delim_run     = 1'b0;
        tok_ovf       = 1'b0;
    endtask

    function automatic record_t make_rec(logic kind, logic [7:0] ch, logic [8:0] len);
        record_t r;
        r.kind = kind;
        r.ch   = ch;
        r.len  = len;
        r.tok  = tok_idx;
        r.ovf  = tok_ovf;
        r.last = 1'b0;
        return r;
    endfunction

    task automatic tokenize_byte(input logic [7:0] b, input logic line_end);
        record_t recs[$];
        if (bslash_run != 0) begin
            if (b == clt_pkg::BSLASH_CH) begin
                if (bslash_run < clt_pkg::SLASH_CAP)
                    bslash_run++;
            end else if (b == clt_pkg::QUOTE_CH) begin
                // half the run survives; odd run escapes the quote
                if (bslash_run[8:1] != 0)
                    recs = {recs, make_rec(clt_pkg::REC_CHAR, clt_pkg::BSLASH_CH,
                                           {1'b0, bslash_run[8:1]})};
                if (bslash_run[0])
                    recs = {recs, make_rec(clt_pkg::REC_CHAR, clt_pkg::QUOTE_CH, 9'd1)};
                else
                    quote_on = !quote_on;
                bslash_run = '0;
            end else begin
                recs = {recs, make_rec(clt_pkg::REC_CHAR, clt_pkg::BSLASH_CH, bslash_run)};
                recs = {recs, make_rec(clt_pkg::REC_CHAR, b, 9'd1)};
                bslash_run = '0;
            end
            delim_run = 1'b0;
        end else if (b == delim_reg) begin
            if (quote_on) begin
                recs = {recs, make_rec(clt_pkg::REC_CHAR, b, 9'd1)};
                delim_run = 1'b0;
            end else if (!delim_run) begin
                delim_run = 1'b1;
                if (!at_line_start) begin
                    if (tok_idx < clt_pkg::TOK_CAP)
                        tok_idx++;
                    else
                        tok_ovf = 1'b1;
                end
            end
        end else if (b == clt_pkg::QUOTE_CH) begin
            quote_on  = !quote_on;
            delim_run = 1'b0;
        end else if (b == clt_pkg::BSLASH_CH) begin
            bslash_run = 9'd1;
            delim_run  = 1'b0;
        end else begin
            recs = {recs, make_rec(clt_pkg::REC_CHAR, b, 9'd1)};
            delim_run = 1'b0;
        end
        at_line_start = 1'b0;

        if (line_end) begin
            if (bslash_run != 0)
                recs = {recs, make_rec(clt_pkg::REC_CHAR, clt_pkg::BSLASH_CH, bslash_run)};
            recs = {recs, make_rec(clt_pkg::REC_SUMMARY, 8'd0, 9'd0)};
            clear_line_state();
        end

        if (recs.size() > 0)
            recs[recs.size()-1].last = 1'b1;
        expected_records = {expected_records, recs};
    endtask

    function automatic int pick_gap();
        int r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // output back-pressure, mostly short stalls
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready = 1'b0;
        end else if (stalls_on && $urandom_range(0, 99) < 25) begin
            stall_left = ($urandom_range(0, 99) < 88) ? $urandom_range(0, 2)
                                                       : $urandom_range(3, 24);
            m_tready = 1'b0;
        end else begin
            m_tready = 1'b1;
        end
    end

    task automatic report_mismatch(input string what, input record_t want, input record_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("[%0t] %s", $realtime, what);
            $display("    expected kind=%0d byte=%02h len=%0d tok=%0d ovf=%0d last=%0d",
                     want.kind, want.ch, want.len, want.tok, want.ovf, want.last);
            $display("    actual   kind=%0d byte=%02h len=%0d tok=%0d ovf=%0d last=%0d",
                     got.kind, got.ch, got.len, got.tok, got.ovf, got.last);
        end
    endtask

    always @(posedge aclk) begin
        record_t got;
        record_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            got.kind = m_tuser;
            got.ch   = m_tdata[7:0];
            got.len  = m_tdata[16:8];
            got.tok  = m_tdata[23:17];
            got.ovf  = m_tdata[24];
            got.last = m_tlast;
            records_checked++;
            if (expected_records.size() == 0) begin
                report_mismatch("record with nothing expected", '0, got);
            end else begin
                want = expected_records.pop_front();
                if (got !== want)
                    report_mismatch("record mismatch", want, got);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic line_end);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = line_end;
        do
            @(posedge aclk);
        while (s_tready !== 1'b1);
        tokenize_byte(b, line_end);
        bytes_sent++;
        if (line_end)
            lines_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string txt, input bit ends_line);
        for (int i = 0; i < txt.len(); i++)
            send_byte(txt[i], ends_line && (i == txt.len() - 1));
    endtask

    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (expected_records.size() != 0)
            @(negedge aclk);
        // bytes that make no record may still sit in the input register
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_delim(input logic [7:0] value);
        wait_idle();
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we    = 1'b0;
        delim_reg = value;
        delim_settings++;
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 28)
            return delim_reg;
        if (r < 42)
            return clt_pkg::QUOTE_CH;
        if (r < 58)
            return clt_pkg::BSLASH_CH;
        if (r < 85)
            return 8'($urandom_range(8'h61, 8'h7A));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_random_line(input int len, input bit noise);
        for (int i = 0; i < len; i++)
            send_byte(noise ? 8'($urandom_range(0, 255)) : pick_byte(), i == len - 1);
    endtask

    // leading delimiters, delimiter runs
    task automatic test_delimiter_runs();
        send_text("  ab  c", 1'b1);
    endtask

    // quote toggling, delimiter inside quotes, unterminated quote at line end
    task automatic test_quotes();
        send_text("\"x y\" z\"", 1'b1);
    endtask

    // even run before quote, odd run before quote, run before a letter, trailing run
    task automatic test_backslashes();
        send_text("\\\\\"a\\\"\\b\\", 1'b1);
    endtask

    task automatic test_byte_extremes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    // index saturates at its cap, overflow flag follows
    task automatic test_token_overflow();
        for (int i = 0; i < 128; i++) begin
            send_byte(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
            repeat ((i % 32 == 0) ? 2 : 1) send_byte(delim_reg, 1'b0);
        end
        send_byte(8'h71, 1'b1);
    endtask

    // slash count saturates; full-length run before another byte
    task automatic test_long_backslash_run();
        send_byte(8'h61, 1'b0);
        repeat (258) send_byte(clt_pkg::BSLASH_CH, 1'b0);
        send_byte(8'h7A, 1'b1);
    endtask

    // delimiter change in the middle of a line, applied from the next byte
    task automatic test_delimiter_config();
        send_text("ab", 1'b0);
        write_delim(8'h3B);
        send_text(" c;;d", 1'b1);
    endtask

    task automatic test_random_lines(input logic [7:0] delim, input int n_items);
        int start;
        int len;
        write_delim(delim);
        start = bytes_sent;
        while (bytes_sent - start < n_items) begin
            gaps_on   = ($urandom_range(0, 4) != 0);
            stalls_on = ($urandom_range(0, 4) != 0);
            len = $urandom_range(1, 16);
            if (len > n_items - (bytes_sent - start))
                len = n_items - (bytes_sent - start);
            send_random_line(len, $urandom_range(0, 9) == 0);
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        delim_reg = clt_pkg::DELIM_RESET;
        clear_line_state();
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        test_delimiter_runs();
        test_quotes();
        test_backslashes();
        test_byte_extremes();
        test_delimiter_config();
        write_delim(clt_pkg::DELIM_RESET);
        test_token_overflow();
        test_long_backslash_run();

        test_random_lines(8'h20, 20);
        test_random_lines(8'h3B, 16);
        test_random_lines(8'h00, 16);
        test_random_lines(8'hFF, 16);
        test_random_lines(clt_pkg::QUOTE_CH, 16);
        test_random_lines(clt_pkg::BSLASH_CH, 16);

        s_tvalid = 1'b0;
        while (expected_records.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Sent %0d bytes in %0d lines under %0d delimiter settings",
                 bytes_sent, lines_sent, delim_settings);
        $display("Checked %0d records, %0d mismatched, %0d still expected",
                 records_checked, mismatches, expected_records.size());
        if (mismatches == 0 && expected_records.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timeout with %0d records still expected", expected_records.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
